/* rtl/ida_pkg.sv */
`timescale 1ns / 1ps
package ida_pkg;
   localparam int unsigned ID_WORDS_DEF    = 128;
   localparam int unsigned QUEUE_DEPTH_DEF = 1024;
   localparam logic [31:0] HOLD_RESET      = 32'd86400;
   localparam logic [31:0] FULL_WORD       = 32'hFFFF_FFFF;

   localparam logic [2:0] OP_ALLOC   = 3'd0;
   localparam logic [2:0] OP_RELEASE = 3'd1;
   localparam logic [2:0] OP_RECLAIM = 3'd2;
   localparam logic [2:0] OP_MARK    = 3'd3;
   localparam logic [2:0] OP_SETMAX  = 3'd4;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_FREE  = 3'd1;
   localparam logic [2:0] ST_Q_FULL   = 3'd2;
   localparam logic [2:0] ST_MISMATCH = 3'd3;
   localparam logic [2:0] ST_RANGE    = 3'd4;

   typedef struct packed {
      logic [2:0]  operation;
      logic [11:0] id;
      logic [31:0] time_req;
      logic [10:0] expected_count;
   } req_type;

   typedef struct packed {
      logic [11:0] alloc_id;
      logic [2:0]  status;
      logic [10:0] reclaimed_count;
      logic [11:0] max_id;
   } rsp_type;

   // index of lowest clear bit (31 when none below 31)
   function automatic logic [4:0] lowest_clear(input logic [31:0] w);
      logic [4:0] b;
      b = 5'd31;
      for (int i = 30; i >= 0; i--) begin
         if (!w[i]) b = 5'(i);
      end
      return b;
   endfunction
endpackage

/* rtl/ida_if.sv */
`timescale 1ns / 1ps
interface ida_req_if import ida_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ida_rsp_if import ida_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ida_csr_if ();
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/id_allocator_with_delayed_reuse_unit.sv */
`timescale 1ns / 1ps
// ID allocator with delayed reuse.
// Channels: req (operation, id, time_req, expected_count), rsp (alloc_id,
// status, reclaimed_count, max_id), csr (hold_time write, taken only while idle).
// Every accepted req item yields exactly one rsp item.
// One item at a time; the bitmap and release queue live in single-port-read
// RAMs, and one sequencer with one read-modify-write path does all the work.
// Steps: set-max and unknown operations go straight to the result; release
// and mark check the range first, then release pushes to the queue and mark
// reads and rewrites one bitmap word; allocate reads bitmap words from the
// search pointer, skipping full words (no read when the map is known full);
// reclaim reads each due queue entry, then reads and clears its bitmap bit.
// Reset: a clearing pass writes the bitmap words (word 0 = 1, rest 0)
// before the first req item is accepted.
// hold_time resets to 86400.
// The result is held in an output register; when rsp is stalled the block
// waits there and takes no new req until the result is taken.
module id_allocator_with_delayed_reuse_unit
   import ida_pkg::*;
#(
   parameter int unsigned ID_WORDS    = ID_WORDS_DEF,
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic   clock,
   input  logic   reset,
   ida_req_if.sink   req,
   ida_rsp_if.source rsp,
   ida_csr_if.sink   csr
);
   localparam int unsigned WU  = (ID_WORDS < 128) ? ID_WORDS : 128;
   localparam int unsigned WAW = (ID_WORDS > 1) ? $clog2(ID_WORDS) : 1;
   localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [12:0] ID_LIMIT = 13'(WU * 32);
   localparam logic [7:0]  WU_C = 8'(WU);

   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_AREAD = 4'd2,
      S_ACHK = 4'd3, S_MREAD = 4'd4, S_MWR = 4'd5, S_QREAD = 4'd6,
      S_QCHK = 4'd7, S_FREAD = 4'd8, S_FWR = 4'd9, S_OUT = 4'd10;

   logic [3:0]     state_ff, state_in;
   logic [WAW-1:0] clr_ff, clr_in;
   req_type        req_ff, req_in;
   rsp_type        rsp_ff, rsp_in;
   logic [7:0]     search_ff, search_in;
   logic [11:0]    high_ff, high_in;
   logic [QAW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [QCW-1:0] cnt_ff, cnt_in;
   logic [10:0]    freed_ff, freed_in;
   logic [31:0]    hold_ff, hold_in;
   logic [11:0]    qid_ff, qid_in;

   // bitmap RAM
   logic           bm_we;
   logic [WAW-1:0] bm_wa, bm_ra;
   logic [31:0]    bm_wd, bm_rd;
   // queue RAM: {id, time}
   logic           q_we;
   logic [43:0]    q_rd;

   ida_ram #(.WIDTH(32), .DEPTH(ID_WORDS)) u_bitmap (
      .clock(clock), .we(bm_we), .waddr(bm_wa), .wdata(bm_wd),
      .raddr(bm_ra), .rdata(bm_rd));

   ida_ram #(.WIDTH(44), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .we(q_we), .waddr(tail_ff),
      .wdata({req_ff.id, req_ff.time_req}), .raddr(head_ff), .rdata(q_rd));

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.data  = rsp_ff;
   assign csr.ready = (state_ff == S_IDLE);

   logic [4:0]  bit_sel;
   logic [11:0] fid;
   logic [6:0]  fwi;
   always_comb begin
      bit_sel = lowest_clear(bm_rd);
      fid     = qid_ff;
      // queued IDs passed the range check, so the word index is in range
      fwi     = fid[11:5];
   end

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      req_in    = req_ff;
      rsp_in    = rsp_ff;
      search_in = search_ff;
      high_in   = high_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      cnt_in    = cnt_ff;
      freed_in  = freed_ff;
      qid_in    = qid_ff;
      hold_in   = (csr.valid && csr.ready) ? csr.data : hold_ff;
      bm_we = 1'b0;
      bm_wa = clr_ff;
      bm_wd = 32'd0;
      bm_ra = WAW'(search_ff);
      q_we  = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            bm_we = 1'b1;
            bm_wa = clr_ff;
            bm_wd = (clr_ff == '0) ? 32'd1 : 32'd0;
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == ID_WORDS - 1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req.valid) begin
               req_in   = req.data;
               freed_in = '0;
               rsp_in   = '0;
               case (req.data.operation)
                  OP_ALLOC: state_in = (search_ff >= WU_C) ? S_ACHK : S_AREAD;
                  OP_RELEASE, OP_MARK: state_in = S_MREAD;
                  OP_RECLAIM: state_in = S_QREAD;
                  OP_SETMAX: begin
                     high_in  = req.data.id;
                     state_in = S_OUT;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_AREAD: begin
            bm_ra    = WAW'(search_ff);
            state_in = S_ACHK;
         end
         S_ACHK: begin
            if (search_ff >= WU_C) begin
               search_in = WU_C;
               rsp_in.status = ST_NO_FREE;
               state_in = S_OUT;
            end else if (bm_rd == FULL_WORD) begin
               search_in = search_ff + 8'd1;
               state_in  = (search_ff + 8'd1 >= WU_C) ? S_ACHK : S_AREAD;
            end else begin
               bm_we = 1'b1;
               bm_wa = WAW'(search_ff);
               bm_wd = bm_rd | (32'd1 << bit_sel);
               rsp_in.alloc_id = {search_ff[6:0], bit_sel};
               if ({search_ff[6:0], bit_sel} > high_ff)
                  high_in = {search_ff[6:0], bit_sel};
               state_in = S_OUT;
            end
         end
         S_MREAD: begin
            if ({1'b0, req_ff.id} >= ID_LIMIT) begin
               rsp_in.status = ST_RANGE;
               state_in = S_OUT;
            end else if (req_ff.operation == OP_RELEASE) begin
               if (32'(cnt_ff) >= QUEUE_DEPTH) rsp_in.status = ST_Q_FULL;
               else begin
                  q_we    = 1'b1;
                  tail_in = (32'(tail_ff) == QUEUE_DEPTH - 1) ? '0 : tail_ff + 1'b1;
                  cnt_in  = cnt_ff + 1'b1;
               end
               state_in = S_OUT;
            end else begin
               bm_ra    = WAW'(req_ff.id[11:5]);
               state_in = S_MWR;
            end
         end
         S_MWR: begin
            bm_we = 1'b1;
            bm_wa = WAW'(req_ff.id[11:5]);
            bm_wd = bm_rd | (32'd1 << req_ff.id[4:0]);
            state_in = S_OUT;
         end
         S_QREAD: begin
            state_in = S_QCHK;
         end
         S_QCHK: begin
            if (cnt_ff != '0 && (q_rd[31:0] + hold_ff) < req_ff.time_req) begin
               qid_in   = q_rd[43:32];
               state_in = S_FREAD;
            end else begin
               rsp_in.reclaimed_count = freed_ff;
               if (freed_ff != req_ff.expected_count) rsp_in.status = ST_MISMATCH;
               state_in = S_OUT;
            end
         end
         S_FREAD: begin
            bm_ra    = WAW'(fwi);
            state_in = S_FWR;
         end
         S_FWR: begin
            bm_we = 1'b1;
            bm_wa = WAW'(fwi);
            bm_wd = bm_rd & ~(32'd1 << fid[4:0]);
            if ({1'b0, fwi} < search_ff) search_in = {1'b0, fwi};
            head_in  = (32'(head_ff) == QUEUE_DEPTH - 1) ? '0 : head_ff + 1'b1;
            cnt_in   = cnt_ff - 1'b1;
            freed_in = freed_ff + 11'd1;
            state_in = S_QREAD;
         end
         S_OUT: begin
            rsp_in.max_id = high_ff;
            if (rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff != S_OUT && state_in == S_OUT) rsp_in.max_id = high_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         search_ff <= '0;
         high_ff   <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         cnt_ff    <= '0;
         hold_ff   <= HOLD_RESET;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         search_ff <= search_in;
         high_ff   <= high_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         cnt_ff    <= cnt_in;
         hold_ff   <= hold_in;
      end
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      freed_ff <= freed_in;
      qid_ff   <= qid_in;
   end
endmodule

/* rtl/ida_ram.sv */
`timescale 1ns / 1ps
module ida_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end
   assign rdata = rdata_ff;
endmodule
